// ===== rtl/core/bam_pkg.sv =====
`timescale 1ns / 1ps

package bam_pkg;

    // Map geometry: the marks are stored eight to a memory row.
    localparam int NUM_BLOCKS = 256;
    localparam int MAX_LIST   = 64;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ROW_W      = 8;
    localparam int COL_W      = $clog2(ROW_W);
    localparam int NUM_ROWS   = NUM_BLOCKS / ROW_W;
    localparam int ROWA_W     = $clog2(NUM_ROWS);
    localparam int ROWC_W     = ROWA_W + 1;
    localparam int LEFT_W     = $clog2(MAX_LIST) + 1;
    localparam int POP_W      = COL_W + 1;

    localparam logic [CNT_W-1:0] BLOCKS_RESET = CNT_W'(NUM_BLOCKS);
    localparam logic [ROW_W-1:0] ROW0_RESET   = ROW_W'(1);

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_READ = 2'd1,
        OP_FIND = 2'd2,
        OP_LIST = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RW_OUT,
        S_SCAN,
        S_RUN_OUT,
        S_CNT_CHK,
        S_LIST_RD,
        S_LIST_LD,
        S_LIST_EMIT,
        S_NOT_FOUND
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic rd_issue;
        logic load;
        logic emit;
        logic push_nf;
        logic push_rw;
        logic push_run;
        logic rewind;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic out_free;
        logic bi_oor;
        logic list_bad;
        logic scan_end;
        logic cnt_short;
        logic pend_empty;
        logic left_last;
    } t_dp_status;

endpackage

// ===== rtl/core/bam_req_if.sv =====
`timescale 1ns / 1ps

interface bam_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [bam_pkg::IDX_W-1:0]  block_index;
    logic                       status_value;
    logic [bam_pkg::CNT_W-1:0]  block_count;

    modport source (output valid, output op, output block_index, output status_value,
                    output block_count, input ready);
    modport sink (input valid, input op, input block_index, input status_value,
                  input block_count, output ready);
endinterface

// ===== rtl/core/bam_rsp_if.sv =====
`timescale 1ns / 1ps

interface bam_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bam_pkg::IDX_W-1:0]  result_index;
    logic                       block_status;
    logic                       found;
    logic                       last;

    modport source (output valid, output result_index, output block_status, output found,
                    output last, input ready);
    modport sink (input valid, input result_index, input block_status, input found,
                  input last, output ready);
endinterface

// ===== rtl/core/bam_ctrl.sv =====
`timescale 1ns / 1ps

module bam_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  bam_pkg::t_dp_status i_status,
    output bam_pkg::t_dp_cmd    o_cmd
);

    bam_pkg::t_state r_state;
    bam_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bam_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            bam_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = bam_pkg::S_DECODE;
                end
            end
            bam_pkg::S_DECODE: begin
                case (i_status.op)
                    bam_pkg::OP_SET, bam_pkg::OP_READ: begin
                        if (i_status.bi_oor) begin
                            n_state = bam_pkg::S_NOT_FOUND;
                        end else begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = bam_pkg::S_RW_OUT;
                        end
                    end
                    bam_pkg::OP_FIND: begin
                        n_state = bam_pkg::S_SCAN;
                    end
                    bam_pkg::OP_LIST: begin
                        n_state = i_status.list_bad ? bam_pkg::S_NOT_FOUND : bam_pkg::S_SCAN;
                    end
                    default: begin
                        n_state = bam_pkg::S_NOT_FOUND;
                    end
                endcase
            end
            bam_pkg::S_RW_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.push_rw = 1'b1;
                    n_state       = bam_pkg::S_IDLE;
                end
            end
            bam_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_end) begin
                    n_state = (i_status.op == bam_pkg::OP_FIND) ? bam_pkg::S_RUN_OUT
                                                                : bam_pkg::S_CNT_CHK;
                end
            end
            bam_pkg::S_RUN_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.push_run = 1'b1;
                    n_state        = bam_pkg::S_IDLE;
                end
            end
            bam_pkg::S_CNT_CHK: begin
                if (i_status.cnt_short) begin
                    n_state = bam_pkg::S_NOT_FOUND;
                end else begin
                    o_cmd.rewind = 1'b1;
                    n_state      = bam_pkg::S_LIST_RD;
                end
            end
            bam_pkg::S_LIST_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = bam_pkg::S_LIST_LD;
            end
            bam_pkg::S_LIST_LD: begin
                o_cmd.load = 1'b1;
                n_state    = bam_pkg::S_LIST_EMIT;
            end
            bam_pkg::S_LIST_EMIT: begin
                if (i_status.pend_empty) begin
                    n_state = bam_pkg::S_LIST_RD;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.left_last) begin
                        n_state = bam_pkg::S_IDLE;
                    end
                end
            end
            bam_pkg::S_NOT_FOUND: begin
                if (i_status.out_free) begin
                    o_cmd.push_nf = 1'b1;
                    n_state       = bam_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bam_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/bam_datapath.sv =====
`timescale 1ns / 1ps

module bam_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bam_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic [1:0]                  i_op,
    input  logic [bam_pkg::IDX_W-1:0]   i_block_index,
    input  logic                        i_status_value,
    input  logic [bam_pkg::CNT_W-1:0]   i_block_count,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [bam_pkg::IDX_W-1:0]   o_result_index,
    output logic                        o_block_status,
    output logic                        o_found,
    output logic                        o_last,
    input  bam_pkg::t_dp_cmd            i_cmd,
    output bam_pkg::t_dp_status         o_status
);

    logic [bam_pkg::CNT_W-1:0]      r_blocks_in_use;
    bam_pkg::t_op                   r_op;
    logic [bam_pkg::IDX_W-1:0]      r_bi;
    logic                           r_sv;
    logic [bam_pkg::CNT_W-1:0]      r_cnt;
    logic [bam_pkg::CNT_W-1:0]      r_n;

    // Row memory; a row whose valid bit is clear is read as its reset marks.
    logic [bam_pkg::ROW_W-1:0]      r_mem [bam_pkg::NUM_ROWS];
    logic [bam_pkg::NUM_ROWS-1:0]   r_row_valid;
    logic [bam_pkg::ROWC_W-1:0]     r_raddr;
    logic [bam_pkg::ROWA_W-1:0]     r_erow;
    logic [bam_pkg::ROW_W-1:0]      r_rdata;
    logic                           r_rvbit;
    logic                           r_rd_vld;

    logic [bam_pkg::CNT_W-1:0]      r_run;
    logic                           r_hit;
    logic [bam_pkg::IDX_W-1:0]      r_start;
    logic [bam_pkg::CNT_W-1:0]      r_freecnt;
    logic [bam_pkg::ROW_W-1:0]      r_pend;
    logic [bam_pkg::LEFT_W-1:0]     r_left;

    logic                           r_out_valid;
    logic [bam_pkg::IDX_W-1:0]      r_out_index;
    logic                           r_out_status;
    logic                           r_out_found;
    logic                           r_out_last;

    logic [bam_pkg::CNT_W-1:0]      cap_n;
    logic [bam_pkg::CNT_W:0]        rows_sum;
    logic [bam_pkg::ROWC_W-1:0]     rows;
    logic [bam_pkg::ROWC_W-1:0]     last_row;
    logic                           issue;
    logic                           eval;
    logic [bam_pkg::ROW_W-1:0]      rd_row;
    logic [bam_pkg::ROW_W-1:0]      inr;
    logic [bam_pkg::ROW_W-1:0]      fr;
    logic [bam_pkg::ROW_W-1:0]      frl;
    logic [bam_pkg::CNT_W-1:0]      need;
    logic [bam_pkg::CNT_W-1:0]      run_v;
    logic                           hit_v;
    logic [bam_pkg::IDX_W-1:0]      start_v;
    logic [bam_pkg::CNT_W-1:0]      tmp_start;
    logic [bam_pkg::POP_W-1:0]      pop;
    logic [bam_pkg::COL_W-1:0]      lo;
    logic                           mark;
    logic [bam_pkg::ROW_W-1:0]      row_new;
    logic                           push_any;

    assign cap_n    = (r_blocks_in_use > bam_pkg::BLOCKS_RESET) ? bam_pkg::BLOCKS_RESET
                                                                 : r_blocks_in_use;
    assign rows_sum = {1'b0, r_n} + (bam_pkg::CNT_W + 1)'(bam_pkg::ROW_W - 1);
    assign rows     = bam_pkg::ROWC_W'(rows_sum >> bam_pkg::COL_W);
    assign last_row = rows - bam_pkg::ROWC_W'(1);
    assign issue    = i_cmd.rd_issue || (i_cmd.scan && (r_raddr < rows));
    assign eval     = i_cmd.scan && r_rd_vld;
    assign need     = (r_cnt == '0) ? bam_pkg::CNT_W'(1) : r_cnt;

    always_comb begin
        if (r_rvbit) begin
            rd_row = r_rdata;
        end else begin
            rd_row = (r_erow == '0) ? bam_pkg::ROW0_RESET : '0;
        end
        for (int j = 0; j < bam_pkg::ROW_W; j++) begin
            inr[j] = {1'b0, r_erow, bam_pkg::COL_W'(j)} < r_n;
        end
        fr  = ~rd_row & inr;
        frl = fr & ~((r_erow == '0) ? bam_pkg::ROW0_RESET : '0);
    end

    // First-fit run tracking across the eight marks of one row.
    always_comb begin
        run_v     = r_run;
        hit_v     = 1'b0;
        start_v   = r_start;
        tmp_start = '0;
        pop       = '0;
        lo        = '0;
        for (int j = 0; j < bam_pkg::ROW_W; j++) begin
            if (fr[j]) begin
                run_v = run_v + bam_pkg::CNT_W'(1);
                if (!hit_v && (run_v >= need)) begin
                    hit_v     = 1'b1;
                    tmp_start = {1'b0, r_erow, bam_pkg::COL_W'(j)} + bam_pkg::CNT_W'(1)
                                - run_v;
                    start_v   = tmp_start[bam_pkg::IDX_W-1:0];
                end
            end else begin
                run_v = '0;
            end
            pop = pop + bam_pkg::POP_W'(frl[j]);
        end
        for (int j = bam_pkg::ROW_W - 1; j >= 0; j--) begin
            if (r_pend[j]) begin
                lo = bam_pkg::COL_W'(j);
            end
        end
    end

    assign mark     = (r_op == bam_pkg::OP_SET) ? r_sv : rd_row[r_bi[bam_pkg::COL_W-1:0]];
    assign push_any = i_cmd.push_nf || i_cmd.push_rw || i_cmd.push_run || i_cmd.emit;

    always_comb begin
        row_new = rd_row;
        row_new[r_bi[bam_pkg::COL_W-1:0]] = r_sv;
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_mem[r_raddr[bam_pkg::ROWA_W-1:0]];
        end
        if (i_cmd.push_rw && (r_op == bam_pkg::OP_SET)) begin
            r_mem[r_bi[bam_pkg::IDX_W-1:bam_pkg::COL_W]] <= row_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= bam_pkg::BLOCKS_RESET;
            r_row_valid     <= '0;
            r_out_valid     <= 1'b0;
            r_rd_vld        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_blocks_in_use <= i_cfg_wdata;
            end
            if (i_cmd.push_rw && (r_op == bam_pkg::OP_SET)) begin
                r_row_valid[r_bi[bam_pkg::IDX_W-1:bam_pkg::COL_W]] <= 1'b1;
            end
            r_rd_vld <= issue;
            if (push_any) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op      <= bam_pkg::t_op'(i_op);
            r_bi      <= i_block_index;
            r_sv      <= i_status_value;
            r_cnt     <= i_block_count;
            r_n       <= cap_n;
            r_run     <= '0;
            r_hit     <= 1'b0;
            r_freecnt <= '0;
            r_left    <= bam_pkg::LEFT_W'(i_block_count);
            if ((bam_pkg::t_op'(i_op) == bam_pkg::OP_SET) ||
                (bam_pkg::t_op'(i_op) == bam_pkg::OP_READ)) begin
                r_raddr <= {1'b0, i_block_index[bam_pkg::IDX_W-1:bam_pkg::COL_W]};
            end else begin
                r_raddr <= '0;
            end
        end else begin
            if (i_cmd.rewind) begin
                r_raddr <= '0;
            end else if (issue) begin
                r_raddr <= r_raddr + bam_pkg::ROWC_W'(1);
            end
            if (eval && (r_op == bam_pkg::OP_FIND)) begin
                r_run <= run_v;
                if (hit_v) begin
                    r_hit   <= 1'b1;
                    r_start <= start_v;
                end
            end
            if (eval && (r_op == bam_pkg::OP_LIST)) begin
                r_freecnt <= r_freecnt + bam_pkg::CNT_W'(pop);
            end
            if (i_cmd.load) begin
                r_pend <= frl;
            end else if (i_cmd.emit) begin
                r_pend[lo] <= 1'b0;
                r_left     <= r_left - bam_pkg::LEFT_W'(1);
            end
        end
        if (issue) begin
            r_erow  <= r_raddr[bam_pkg::ROWA_W-1:0];
            r_rvbit <= r_row_valid[r_raddr[bam_pkg::ROWA_W-1:0]];
        end
        if (i_cmd.push_nf || (i_cmd.push_run && !r_hit)) begin
            r_out_index  <= '0;
            r_out_status <= 1'b0;
            r_out_found  <= 1'b0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.push_run) begin
            r_out_index  <= r_start;
            r_out_status <= 1'b0;
            r_out_found  <= 1'b1;
            r_out_last   <= 1'b1;
        end else if (i_cmd.push_rw) begin
            r_out_index  <= r_bi;
            r_out_status <= mark;
            r_out_found  <= 1'b1;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_index  <= {r_erow, lo};
            r_out_status <= 1'b0;
            r_out_found  <= 1'b1;
            r_out_last   <= (r_left == bam_pkg::LEFT_W'(1));
        end
    end

    always_comb begin
        o_status.op         = r_op;
        o_status.out_free   = !r_out_valid || i_out_ready;
        o_status.bi_oor     = {1'b0, r_bi} >= r_n;
        o_status.list_bad   = (r_cnt == '0) || (r_cnt > bam_pkg::CNT_W'(bam_pkg::MAX_LIST));
        o_status.scan_end   = i_cmd.scan &&
                              ((r_rd_vld && (((r_op == bam_pkg::OP_FIND) && hit_v) ||
                                             ({1'b0, r_erow} == last_row))) ||
                               (!r_rd_vld && (r_raddr >= rows)));
        o_status.cnt_short  = r_freecnt < r_cnt;
        o_status.pend_empty = (r_pend == '0);
        o_status.left_last  = (r_left == bam_pkg::LEFT_W'(1));
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_out_index;
    assign o_block_status = r_out_status;
    assign o_found        = r_out_found;
    assign o_last         = r_out_last;

endmodule

// ===== rtl/core/block_allocation_map_top.sv =====
`timescale 1ns / 1ps

// First-fit bitmap block allocator. The block keeps one used/free mark per storage
// block (1 used, 0 free); after reset block 0 is used and every other block is free.
// Each request item on i_req either sets a mark, reads a mark, searches first-fit for a
// run of free blocks, or lists the first N free blocks from block 1 upward. Searches
// cover only blocks below the configured count (capped at 256), written through
// i_cfg_we / i_cfg_wdata. The user must write it only while the block is idle; the
// block itself does not enforce this. Every request yields one result item on o_rsp,
// except a successful list, which yields N items with last set on the final one. A
// failed search, a bad list size or an out-of-range index gives a single item with
// found and result_index both zero. Requests are handled one at a time; a new request
// is taken as soon as the previous one has placed its last result in the output
// register. The marks are held eight to a row of a single-port memory: a set or read
// reads its one row, a run search evaluates one row per cycle and stops at the first
// fit, and a list of N blocks first counts the free blocks in range, then reads the
// rows again and emits one result per free block until N are out.
// There is no clearing pass after reset: per-row valid bits stand in for the reset map.

module block_allocation_map_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bam_pkg::CNT_W-1:0]   i_cfg_wdata,
    bam_req_if.sink                     i_req,
    bam_rsp_if.source                   o_rsp
);

    // Command and status groups between the sequencer and the datapath.
    bam_pkg::t_dp_cmd    dp_cmd;
    bam_pkg::t_dp_status dp_status;

    bam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // The datapath owns the mark memory, the scan counters and the output register.
    bam_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (i_req.op),
        .i_block_index  (i_req.block_index),
        .i_status_value (i_req.status_value),
        .i_block_count  (i_req.block_count),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_result_index (o_rsp.result_index),
        .o_block_status (o_rsp.block_status),
        .o_found        (o_rsp.found),
        .o_last         (o_rsp.last),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status)
    );

endmodule

// ===== rtl/core/bam_checker.sv =====
`timescale 1ns / 1ps

module bam_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [bam_pkg::IDX_W-1:0]   i_result_index,
    input  logic                        i_block_status,
    input  logic                        i_found,
    input  logic                        i_last
);

    // A result item that is stalled stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result item dropped while stalled");

    // A not-found result is always the only and final one, with zero payload.
    a_nf_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |->
            (i_last && (i_result_index == '0) && !i_block_status))
        else $error("malformed not-found result");

    // While a list is still delivering, no new request is taken.
    a_list_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_last) |-> !i_in_ready)
        else $error("request taken during a list");

    // A request is never taken back to back.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken back to back");

endmodule

bind block_allocation_map_top bam_checker u_bam_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_result_index (o_rsp.result_index),
    .i_block_status (o_rsp.block_status),
    .i_found        (o_rsp.found),
    .i_last         (o_rsp.last)
);

// ===== tb/bam_reply_checker.sv =====
`timescale 1ns / 1ps

module bam_reply_checker
    import bam_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    bam_req_if               i_req,
    bam_rsp_if               i_rsp,
    output int               o_mismatches,
    output int               o_replies_due
);

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             status;
        logic             found;
        logic             last;
    } t_map_reply;

    // Our own copy of the allocation map and of the block limit register.
    logic [NUM_BLOCKS-1:0] mark_map       = NUM_BLOCKS'(1);
    logic [CNT_W-1:0]      block_limit    = BLOCKS_RESET;
    t_map_reply            map_replies_due[$];
    int                    mismatch_count = 0;
    int                    due_count      = 0;

    assign o_mismatches  = mismatch_count;
    assign o_replies_due = due_count;

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    function automatic void push_reply(int index, logic status, logic found, logic last);
        t_map_reply reply;
        reply.index  = IDX_W'(index);
        reply.status = status;
        reply.found  = found;
        reply.last   = last;
        map_replies_due.push_back(reply);
    endfunction

    // Works out every reply item that one request causes and updates the map.
    function automatic void compute_map_replies(t_op op, logic [IDX_W-1:0] blk, logic mark,
                                                logic [CNT_W-1:0] count);
        int active;
        int need;
        int run_len;
        int start_at;
        int free_total;
        int listed;
        int i;
        active = (block_limit > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_limit);
        case (op)
            OP_SET, OP_READ: begin
                if (int'(blk) >= active) begin
                    push_reply(0, 1'b0, 1'b0, 1'b1);
                end else begin
                    if (op == OP_SET) begin
                        mark_map[blk] = mark;
                    end
                    push_reply(int'(blk), mark_map[blk], 1'b1, 1'b1);
                end
            end
            OP_FIND: begin
                // A zero length is searched as a single block.
                need     = (count == '0) ? 1 : int'(count);
                run_len  = 0;
                start_at = -1;
                for (i = 0; i < active && start_at < 0; i++) begin
                    if (mark_map[i]) begin
                        run_len = 0;
                    end else begin
                        run_len++;
                        if (run_len >= need) begin
                            start_at = i + 1 - run_len;
                        end
                    end
                end
                if (start_at < 0) begin
                    push_reply(0, 1'b0, 1'b0, 1'b1);
                end else begin
                    push_reply(start_at, 1'b0, 1'b1, 1'b1);
                end
            end
            default: begin
                free_total = 0;
                for (i = 1; i < active; i++) begin
                    if (!mark_map[i]) begin
                        free_total++;
                    end
                end
                if (count == '0 || int'(count) > MAX_LIST || free_total < int'(count)) begin
                    push_reply(0, 1'b0, 1'b0, 1'b1);
                end else begin
                    listed = 0;
                    for (i = 1; i < active && listed < int'(count); i++) begin
                        if (!mark_map[i]) begin
                            listed++;
                            push_reply(i, 1'b0, 1'b1, listed == int'(count));
                        end
                    end
                end
            end
        endcase
    endfunction

    task automatic check_reply();
        t_map_reply want;
        if (map_replies_due.size() == 0) begin
            report_mismatch($sformatf("reply index %0d with no reply outstanding",
                                      i_rsp.result_index));
            return;
        end
        want = map_replies_due.pop_front();
        if (i_rsp.result_index !== want.index) begin
            report_mismatch($sformatf("result_index got %0d want %0d",
                                      i_rsp.result_index, want.index));
        end
        if (i_rsp.block_status !== want.status) begin
            report_mismatch($sformatf("block_status got %b want %b",
                                      i_rsp.block_status, want.status));
        end
        if (i_rsp.found !== want.found) begin
            report_mismatch($sformatf("found got %b want %b", i_rsp.found, want.found));
        end
        if (i_rsp.last !== want.last) begin
            report_mismatch($sformatf("last got %b want %b", i_rsp.last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mark_map    = NUM_BLOCKS'(1);
            block_limit = BLOCKS_RESET;
            map_replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                block_limit = i_cfg_wdata;
            end
            if (i_rsp.valid && i_rsp.ready) begin
                check_reply();
            end
            if (i_req.valid && i_req.ready) begin
                compute_map_replies(t_op'(i_req.op), i_req.block_index, i_req.status_value,
                                    i_req.block_count);
            end
        end
        due_count <= map_replies_due.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bam_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_wdata;

    bam_req_if req_ch ();
    bam_rsp_if rsp_ch ();

    int mismatches;
    int replies_due;

    // Stimulus bookkeeping. The block limit mirrors what was last written to the
    // register, so that random indexes land mostly inside the searched range.
    int block_limit       = NUM_BLOCKS;
    int items_sent        = 0;
    bit sender_idle_on    = 1'b1;
    bit receiver_idle_on  = 1'b1;
    bit long_hold_request = 1'b0;
    int stall_left        = 0;

    block_allocation_map_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    // The checker sits beside the block, watching both channels and the register port.
    // It predicts every reply item and hands its mismatch count back for the verdict.
    bam_reply_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_mismatches (mismatches),
        .o_replies_due(replies_due)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = ~i_clk;
        end
    end

    // The slowest correct run, with every request listing 64 blocks and every reply
    // waiting out a full stall, stays well below this bound.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // Reply side. Ready is dropped at random while idling is enabled. A long hold-off
    // request overrides that: ready stays low for a long stretch so that a list request
    // backs up through the block and stalls its input.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_request) begin
                stall_left        = 240;
                long_hold_request = 1'b0;
            end else if (stall_left == 0 && receiver_idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 13);
            end
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Offers one request item and returns at the falling edge after it was accepted.
    // Valid is lowered only when an idle gap is inserted, so back-to-back items keep it
    // high without ever toggling it within one time step.
    task automatic send_request(t_op op, int blk, bit mark, int count);
        int gap;
        gap = 0;
        if (sender_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 13);
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.block_index  <= IDX_W'(blk);
        req_ch.status_value <= mark;
        req_ch.block_count  <= CNT_W'(count);
        do begin
            @(posedge i_clk);
        end while (!req_ch.ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // Stops offering requests and waits until every predicted reply has come back.
    // It then returns only once the block is back in its idle state.
    task automatic wait_until_drained();
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (replies_due != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // The block limit may only change while the block is idle.
    task automatic write_block_limit(int value);
        wait_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CNT_W'(value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        block_limit = value;
        @(negedge i_clk);
    endtask

    // One random request. Sets dominate so that the map fills and empties over time,
    // and now and then a short stretch of neighbors is claimed or released together,
    // which builds the fragmented layouts that make the run search interesting.
    task automatic send_random_item();
        int active;
        int pick;
        int blk;
        int count;
        int span;
        int k;
        bit mark;
        active = (block_limit > NUM_BLOCKS) ? NUM_BLOCKS : block_limit;
        pick   = $urandom_range(0, 99);
        if (active == 0 || $urandom_range(0, 6) == 0) begin
            blk = $urandom_range(0, NUM_BLOCKS - 1);
        end else begin
            blk = $urandom_range(0, active - 1);
        end
        mark  = $urandom_range(0, 1);
        count = $urandom_range(0, 511);
        if (pick < 14) begin
            span = $urandom_range(2, 8);
            for (k = 0; k < span; k++) begin
                send_request(OP_SET, (blk + k) % NUM_BLOCKS, mark, $urandom_range(0, 511));
            end
        end else if (pick < 40) begin
            send_request(OP_SET, blk, mark, count);
        end else if (pick < 55) begin
            send_request(OP_READ, blk, mark, count);
        end else if (pick < 78) begin
            // Mostly short runs, some long ones, and once in a while any length at all.
            k = $urandom_range(0, 9);
            if (k < 7) begin
                count = $urandom_range(0, 8);
            end else if (k < 9) begin
                count = $urandom_range(9, 48);
            end
            send_request(OP_FIND, blk, mark, count);
        end else begin
            // Lists are kept short so that the run stays quick; a few go up to the
            // maximum, and the occasional oversized or zero size must be refused.
            k = $urandom_range(0, 9);
            if (k < 7) begin
                count = $urandom_range(1, 6);
            end else if (k < 9) begin
                count = $urandom_range(7, MAX_LIST);
            end
            send_request(OP_LIST, blk, mark, count);
        end
    endtask

    initial begin
        int limits[7];
        int phase;
        int phase_end;
        int k;

        limits = '{NUM_BLOCKS, 37, 511, 9, 130, 2, NUM_BLOCKS};

        // Every input is known from time zero, while reset is held low.
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_SET;
        req_ch.block_index  = '0;
        req_ch.status_value = 1'b0;
        req_ch.block_count  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, starting from the reset map where only block 0 is in use.
        send_request(OP_READ, 0, 1'b0, 0);
        send_request(OP_READ, 255, 1'b1, 511);
        send_request(OP_SET, 255, 1'b1, 511);
        send_request(OP_SET, 0, 1'b0, 0);
        // A zero length acts as one block, and block 0 is free just now.
        send_request(OP_FIND, 0, 1'b0, 0);
        send_request(OP_SET, 0, 1'b1, 0);
        send_request(OP_FIND, 0, 1'b0, 254);
        send_request(OP_FIND, 0, 1'b0, 255);
        // A run as long as the whole range, or longer, does not fit.
        send_request(OP_FIND, 0, 1'b0, 256);
        send_request(OP_FIND, 0, 1'b0, 511);
        // List sizes of zero and above the maximum are refused.
        send_request(OP_LIST, 0, 1'b0, 0);
        send_request(OP_LIST, 0, 1'b0, MAX_LIST + 1);
        send_request(OP_LIST, 0, 1'b0, MAX_LIST);
        send_request(OP_LIST, 0, 1'b0, 1);
        send_request(OP_SET, 255, 1'b0, 0);

        // A range of two blocks: only blocks 0 and 1 are searched.
        write_block_limit(2);
        send_request(OP_READ, 1, 1'b0, 0);
        send_request(OP_READ, 2, 1'b0, 0);
        send_request(OP_SET, 255, 1'b1, 0);
        send_request(OP_FIND, 0, 1'b0, 1);
        send_request(OP_FIND, 0, 1'b0, 2);
        send_request(OP_LIST, 0, 1'b0, 1);
        // Only one free block lies in range, so a list of two is too many.
        send_request(OP_LIST, 0, 1'b0, 2);

        // Limits of zero and one leave an empty or nearly empty range.
        write_block_limit(0);
        send_request(OP_FIND, 0, 1'b0, 1);
        send_request(OP_READ, 0, 1'b0, 0);
        write_block_limit(1);
        send_request(OP_LIST, 0, 1'b0, 1);
        send_request(OP_FIND, 0, 1'b0, 1);

        // Random part, one phase per limit setting. The limit above the map size must
        // behave exactly like the full map.
        for (phase = 0; phase < 7; phase++) begin
            write_block_limit(limits[phase]);
            phase_end = items_sent + 48;
            k = 0;
            while (items_sent < phase_end) begin
                // Idling is switched on and off in stretches, and is off in the last phase.
                if (phase == 6) begin
                    sender_idle_on   = 1'b0;
                    receiver_idle_on = 1'b0;
                end else if (k % 20 == 0) begin
                    sender_idle_on   = $urandom_range(0, 2) != 0;
                    receiver_idle_on = $urandom_range(0, 2) != 0;
                end
                if (phase == 0 && k == 15) begin
                    // Hold the reply side for a long time while a full-size list and
                    // more requests are offered, so the block backs up and stalls.
                    wait_until_drained();
                    long_hold_request = 1'b1;
                    send_request(OP_LIST, 0, 1'b0, MAX_LIST);
                    repeat (4) send_random_item();
                end else if (phase == 0 && k == 30) begin
                    // Pause the request side until every reply has come back.
                    wait_until_drained();
                end
                send_random_item();
                k++;
            end
        end

        // Wait for the last replies, then leave room for any stray extra item.
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (replies_due != 0);
        repeat (300) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
